[rtl/rsf_pkg.sv]
// ----------------------------------------------------------------------------
// rsf_pkg
// Shared types, segment tables and range limits of the reading formatter.
// ----------------------------------------------------------------------------
package rsf_pkg;

    // three segment bytes of one display, leftmost first
    typedef struct packed {
        logic [7:0] left;
        logic [7:0] mid;
        logic [7:0] right;
    } seg3_t;

    // five decimal digits of a magnitude, index 0 is the units digit
    typedef logic [4:0][3:0] digits_t;

    // temperature display codes
    localparam logic [7:0] T_SEG_E     = 8'h4F;
    localparam logic [7:0] T_SEG_R     = 8'h42;
    localparam logic [7:0] T_SEG_MINUS = 8'h40;
    localparam logic [7:0] T_SEG_ZERO  = 8'hAF;
    localparam logic [7:0] T_DOT       = 8'h10;
    localparam logic [7:0] SEG_BLANK   = 8'h00;

    // humidity display codes
    localparam logic [7:0] H_SEG_E     = 8'hF4;
    localparam logic [7:0] H_SEG_R     = 8'h44;
    localparam logic [7:0] H_SEG_ZERO  = 8'hFA;
    localparam logic [7:0] H_DOT       = 8'h01;

    // range limits
    localparam logic signed [15:0] C_MAX_EXCL = 16'sd1501;
    localparam logic signed [15:0] C_MIN      = -16'sd550;
    localparam logic signed [15:0] F_MAX      = 16'sd30218;
    localparam logic signed [15:0] F_MIN      = -16'sd6700;
    localparam logic signed [15:0] F_NEG_MIN  = -16'sd5000;
    localparam logic signed [15:0] H_MAX_EXCL = 16'sd1000;

    // reciprocal multipliers, exact for magnitudes below 2^15
    localparam logic [31:0] RECIP_10    = 32'd52429;
    localparam int          SHIFT_10    = 19;
    localparam logic [31:0] RECIP_100   = 32'd5243;
    localparam int          SHIFT_100   = 19;
    localparam logic [31:0] RECIP_1000  = 32'd33555;
    localparam int          SHIFT_1000  = 25;
    localparam logic [31:0] RECIP_10000 = 32'd13422;
    localparam int          SHIFT_10000 = 27;

    function automatic logic [7:0] tseg(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'hAF;
            4'd1:    s = 8'hA0;
            4'd2:    s = 8'hCB;
            4'd3:    s = 8'hE9;
            4'd4:    s = 8'hE4;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h6F;
            4'd7:    s = 8'hA8;
            4'd8:    s = 8'hEF;
            4'd9:    s = 8'hED;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] hseg(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'hFA;
            4'd1:    s = 8'h0A;
            4'd2:    s = 8'hD6;
            4'd3:    s = 8'h9E;
            4'd4:    s = 8'h2E;
            4'd5:    s = 8'hBC;
            4'd6:    s = 8'hFC;
            4'd7:    s = 8'h1A;
            4'd8:    s = 8'hFE;
            4'd9:    s = 8'hBE;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

[rtl/rsf_digits.sv]
// ----------------------------------------------------------------------------
// rsf_digits
// Splits a 15-bit magnitude into five decimal digits by reciprocal multiply.
// ----------------------------------------------------------------------------
module rsf_digits
    import rsf_pkg::*;
(
    input  logic [14:0] value,
    output digits_t     digits
);

    logic [31:0] prod_10;
    logic [31:0] prod_100;
    logic [31:0] prod_1000;
    logic [31:0] prod_10000;
    logic [11:0] quot_10;
    logic [8:0]  quot_100;
    logic [5:0]  quot_1000;
    logic [1:0]  quot_10000;
    logic [14:0] rem_0;
    logic [11:0] rem_1;
    logic [8:0]  rem_2;
    logic [5:0]  rem_3;

    // every quotient straight from the input, so no product feeds another
    assign prod_10    = {17'd0, value} * RECIP_10;
    assign prod_100   = {17'd0, value} * RECIP_100;
    assign prod_1000  = {17'd0, value} * RECIP_1000;
    assign prod_10000 = {17'd0, value} * RECIP_10000;

    assign quot_10    = prod_10[SHIFT_10 +: 12];
    assign quot_100   = prod_100[SHIFT_100 +: 9];
    assign quot_1000  = prod_1000[SHIFT_1000 +: 6];
    assign quot_10000 = prod_10000[SHIFT_10000 +: 2];

    assign rem_0 = value - 15'(quot_10) * 15'd10;
    assign rem_1 = quot_10 - 12'(quot_100) * 12'd10;
    assign rem_2 = quot_100 - 9'(quot_1000) * 9'd10;
    assign rem_3 = quot_1000 - 6'(quot_10000) * 6'd10;

    assign digits[0] = rem_0[3:0];
    assign digits[1] = rem_1[3:0];
    assign digits[2] = rem_2[3:0];
    assign digits[3] = rem_3[3:0];
    assign digits[4] = {2'b00, quot_10000};

endmodule

[rtl/rsf_temp_fmt.sv]
// ----------------------------------------------------------------------------
// rsf_temp_fmt
// Temperature segment bytes for Celsius tenths or Fahrenheit hundredths.
// ----------------------------------------------------------------------------
module rsf_temp_fmt
    import rsf_pkg::*;
(
    input  logic               unit_mode,
    input  logic signed [15:0] temperature,
    input  digits_t            digits,
    output seg3_t              bytes,
    output logic               hold
);

    always_comb
    begin
        bytes = '{left: T_SEG_E, mid: T_SEG_R, right: T_SEG_R};
        hold  = 1'b0;
        if (!unit_mode)
        begin
            if (temperature >= C_MAX_EXCL || temperature < C_MIN)
            begin
                bytes = '{left: T_SEG_E, mid: T_SEG_R, right: T_SEG_R};
            end
            else if (temperature > 16'sd999)
            begin
                bytes.left  = tseg(digits[3]) | T_DOT;
                bytes.mid   = tseg(digits[2]);
                bytes.right = tseg(digits[1]);
            end
            else if (!temperature[15])
            begin
                // leading zero blanked, dot kept
                bytes.left  = (digits[2] == 4'd0) ? T_DOT : (tseg(digits[2]) | T_DOT);
                bytes.mid   = tseg(digits[1]) | T_DOT;
                bytes.right = tseg(digits[0]);
            end
            else if (temperature > -16'sd100)
            begin
                bytes.left  = T_SEG_MINUS | T_DOT;
                bytes.mid   = tseg(digits[1]) | T_DOT;
                bytes.right = tseg(digits[0]);
            end
            else
            begin
                // tenths dropped, whole degrees only
                bytes.left  = T_SEG_MINUS | T_DOT;
                bytes.mid   = tseg(digits[2]);
                bytes.right = tseg(digits[1]);
            end
        end
        else
        begin
            if (temperature > F_MAX || temperature < F_MIN)
            begin
                bytes = '{left: T_SEG_E, mid: T_SEG_R, right: T_SEG_R};
            end
            else if (temperature > 16'sd9999)
            begin
                bytes.left  = tseg(digits[4]);
                bytes.mid   = tseg(digits[3]);
                bytes.right = tseg(digits[2]) | T_DOT;
            end
            else if (temperature > 16'sd9)
            begin
                bytes.left  = (digits[3] == 4'd0) ? SEG_BLANK : tseg(digits[3]);
                bytes.mid   = tseg(digits[2]) | T_DOT;
                bytes.right = tseg(digits[1]) | T_DOT;
            end
            else if (temperature > 16'sd0)
            begin
                bytes.left  = SEG_BLANK;
                bytes.mid   = SEG_BLANK;
                bytes.right = T_SEG_ZERO | T_DOT;
            end
            else if (temperature <= -16'sd4 && temperature >= -16'sd9)
            begin
                bytes.left  = T_SEG_MINUS;
                bytes.mid   = T_SEG_ZERO;
                bytes.right = tseg(digits[0]) | T_DOT;
            end
            else if (temperature <= -16'sd10 && temperature >= -16'sd999)
            begin
                bytes.left  = T_SEG_MINUS;
                bytes.mid   = tseg(digits[2]) | T_DOT;
                bytes.right = tseg(digits[1]) | T_DOT;
            end
            else if (temperature < -16'sd999 && temperature >= F_NEG_MIN)
            begin
                bytes.left  = T_SEG_MINUS;
                bytes.mid   = tseg(digits[3]);
                bytes.right = tseg(digits[2]) | T_DOT;
            end
            else
            begin
                // zero, just below zero and the deep negative band keep what is shown
                hold = 1'b1;
            end
        end
    end

endmodule

[rtl/reading_to_segment_formatter_unit.sv]
// ----------------------------------------------------------------------------
// reading_to_segment_formatter_unit
// Formats a temperature and a humidity reading into six segment bytes.
// ----------------------------------------------------------------------------
//  channel    direction  handshake                   payload
//  input      in         in_valid / in_stall         temperature, humidity,
//                                                    sensor_error
//  output     out        out_valid / out_stall       temp_*_seg, hum_*_seg
//  unit mode  in         unit_mode_we                unit_mode_wdata
//
//  one beat per cycle sustained while out_stall is low; a taken beat passes
//  through the input register, then the result register
//  reset clears both valid flags, the unit mode and the shown temperature bytes
//  a stalled result holds the result register; the input register still takes
//  a beat and in_stall rises only while both registers are full and the
//  result is stalled
//  the shown temperature bytes are what a reading in the Fahrenheit gap keeps
// ----------------------------------------------------------------------------
module reading_to_segment_formatter_unit
    import rsf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               unit_mode_we,
    input  logic               unit_mode_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] temperature,
    input  logic signed [15:0] humidity,
    input  logic               sensor_error,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         temp_left_seg,
    output logic [7:0]         temp_mid_seg,
    output logic [7:0]         temp_right_seg,
    output logic [7:0]         hum_left_seg,
    output logic [7:0]         hum_mid_seg,
    output logic [7:0]         hum_right_seg
);

    logic               unit_mode_reg;
    logic               in_valid_reg;
    logic signed [15:0] temp_reg;
    logic signed [15:0] hum_reg;
    logic               err_reg;
    logic               out_valid_reg;
    seg3_t              temp_seg_reg;
    seg3_t              hum_seg_reg;
    seg3_t              temp_seg_next;
    seg3_t              hum_seg_next;
    seg3_t              temp_fmt;
    logic               temp_hold;
    logic               advance;
    logic               take;
    logic [15:0]        temp_neg;
    logic [14:0]        temp_mag;
    digits_t            temp_digits;
    digits_t            hum_digits;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_mode_reg <= 1'b0;
        end
        else if (unit_mode_we)
        begin
            unit_mode_reg <= unit_mode_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            temp_reg <= temperature;
            hum_reg  <= humidity;
            err_reg  <= sensor_error;
        end
    end

    assign temp_neg = ~temp_reg + 16'd1;
    assign temp_mag = temp_reg[15] ? temp_neg[14:0] : temp_reg[14:0];

    rsf_digits u_temp_digits
    (
        .value  (temp_mag),
        .digits (temp_digits)
    );

    rsf_digits u_hum_digits
    (
        .value  (hum_reg[14:0]),
        .digits (hum_digits)
    );

    rsf_temp_fmt u_temp_fmt
    (
        .unit_mode   (unit_mode_reg),
        .temperature (temp_reg),
        .digits      (temp_digits),
        .bytes       (temp_fmt),
        .hold        (temp_hold)
    );

    always_comb
    begin
        if (hum_reg >= H_MAX_EXCL || hum_reg <= 16'sd0)
        begin
            hum_seg_next = '{left: H_SEG_E, mid: H_SEG_R, right: H_SEG_R};
        end
        else
        begin
            hum_seg_next.left  = (hum_digits[2] == 4'd0) ? H_DOT
                                                         : (hseg(hum_digits[2]) | H_DOT);
            hum_seg_next.mid   = hseg(hum_digits[1]) | H_DOT;
            hum_seg_next.right = hseg(hum_digits[0]) | H_DOT;
        end

        temp_seg_next = temp_hold ? temp_seg_reg : temp_fmt;

        // sensor failure overrides both readings
        if (err_reg)
        begin
            temp_seg_next = '{left: T_SEG_E, mid: T_SEG_R, right: T_SEG_R};
            hum_seg_next  = '{left: H_SEG_E, mid: H_SEG_R, right: H_SEG_R};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            temp_seg_reg  <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                temp_seg_reg  <= temp_seg_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hum_seg_reg <= hum_seg_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign temp_left_seg  = temp_seg_reg.left;
    assign temp_mid_seg   = temp_seg_reg.mid;
    assign temp_right_seg = temp_seg_reg.right;
    assign hum_left_seg   = hum_seg_reg.left;
    assign hum_mid_seg    = hum_seg_reg.mid;
    assign hum_right_seg  = hum_seg_reg.right;

    a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !in_stall)
        else $error("input stalled with empty input register");

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled while result register could move");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register empty after a beat moved in");

    a_error_shows_err: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && err_reg) |=> (temp_seg_reg.left == T_SEG_E && hum_seg_reg.left == H_SEG_E))
        else $error("sensor error beat did not show Err");

endmodule
